>>> rtl/core/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Types and constants shared by the snore event detector core.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned SMALL_W  = 6;

    // stream payload layout
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 88;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SNORE_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUT_GAP_MS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_DELAY_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOWS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POOR_DET_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIR_DET_LIMIT   = 3'd5;

    // configuration reset values
    localparam logic [DATA_W-1:0]  RST_SNORE_THRESHOLD = 32'd100000000;
    localparam logic [DATA_W-1:0]  RST_BOUT_GAP_MS     = 32'd120000;
    localparam logic [DATA_W-1:0]  RST_SCORE_DELAY_MS  = 32'd20000;
    localparam logic [SMALL_W-1:0] RST_MIN_WINDOWS     = 6'd10;
    localparam logic [SMALL_W-1:0] RST_POOR_DET_LIMIT  = 6'd12;
    localparam logic [SMALL_W-1:0] RST_FAIR_DET_LIMIT  = 6'd5;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLOSE  = 1'b1;

    // window extremes are held with the sign bit flipped
    localparam logic [DATA_W-1:0] SIGN_BIAS   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WIN_MAX_RST = 32'h0000_0000;
    localparam logic [DATA_W-1:0] WIN_MIN_RST = 32'hFFFF_FFFF;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // history class codes
    typedef logic [1:0] class_t;
    localparam class_t CLASS_QUIET = 2'd0;
    localparam class_t CLASS_SNORE = 2'd1;
    localparam class_t CLASS_BOUT  = 2'd2;

    // recent grade codes
    typedef logic [1:0] grade_t;
    localparam grade_t GRADE_CALIB = 2'd0;
    localparam grade_t GRADE_GOOD  = 2'd1;
    localparam grade_t GRADE_FAIR  = 2'd2;
    localparam grade_t GRADE_POOR  = 2'd3;

    // overall score codes
    typedef logic [1:0] score_t;
    localparam score_t SCORE_GOOD = 2'd0;
    localparam score_t SCORE_FAIR = 2'd1;
    localparam score_t SCORE_POOR = 2'd2;

    // recent bout limits
    localparam int unsigned RECENT_BOUT_POOR = 3;
    localparam int unsigned RECENT_BOUT_FAIR = 2;

    // overall score limits
    localparam logic [COUNT_W-1:0] GOOD_SNORE_BELOW = 16'd5;
    localparam logic [COUNT_W-1:0] GOOD_BOUT_BELOW  = 16'd2;
    localparam logic [COUNT_W-1:0] POOR_SNORE_ABOVE = 16'd15;
    localparam logic [COUNT_W-1:0] POOR_BOUT_ABOVE  = 16'd3;

    function automatic score_t overall_of(input logic [COUNT_W-1:0] snores,
                                          input logic [COUNT_W-1:0] bouts);
        score_t s;
        if (snores < GOOD_SNORE_BELOW && bouts < GOOD_BOUT_BELOW) begin
            s = SCORE_GOOD;
        end else if (snores > POOR_SNORE_ABOVE || bouts > POOR_BOUT_ABOVE) begin
            s = SCORE_POOR;
        end else begin
            s = SCORE_FAIR;
        end
        return s;
    endfunction

endpackage

>>> rtl/core/sed_history.sv
// ----------------------------------------------------------------------------
// sed_history
// Ring of window classes in a synchronous RAM, with running detection and
// bout counts. The entry to be overwritten is read ahead into a register.
// ----------------------------------------------------------------------------
module sed_history #(
    parameter int unsigned DEPTH = 50
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  sed_pkg::class_t               wr_class,
    output logic [$clog2(DEPTH+1)-1:0]    det_sum,
    output logic [$clog2(DEPTH+1)-1:0]    bout_sum,
    output logic [$clog2(DEPTH+1)-1:0]    filled
);

    localparam int unsigned POS_W = $clog2(DEPTH);
    localparam int unsigned SUM_W = $clog2(DEPTH+1);

    sed_pkg::class_t ring_mem [DEPTH];
    sed_pkg::class_t rd_class_reg;

    logic [POS_W-1:0] ring_pos_reg;
    logic [POS_W-1:0] ring_pos_next;
    logic             ring_full_reg;
    logic             wrap;
    logic [SUM_W-1:0] det_sum_reg;
    logic [SUM_W-1:0] bout_sum_reg;
    logic             det_inc;
    logic             det_dec;
    logic             bout_inc;
    logic             bout_dec;

    assign wrap = (ring_pos_reg == POS_W'(DEPTH - 1));

    always_comb begin
        ring_pos_next = ring_pos_reg;
        if (wr_en) begin
            ring_pos_next = wrap ? '0 : ring_pos_reg + POS_W'(1);
        end
    end

    // rd_class_reg always holds the entry at ring_pos_reg
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[ring_pos_reg] <= wr_class;
        end
        rd_class_reg <= ring_mem[ring_pos_next];
    end

    assign det_inc  = (wr_class != sed_pkg::CLASS_QUIET);
    assign bout_inc = (wr_class == sed_pkg::CLASS_BOUT);
    assign det_dec  = ring_full_reg && (rd_class_reg != sed_pkg::CLASS_QUIET)
                      && (det_sum_reg != '0);
    assign bout_dec = ring_full_reg && (rd_class_reg == sed_pkg::CLASS_BOUT)
                      && (bout_sum_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_pos_reg  <= '0;
            ring_full_reg <= 1'b0;
            det_sum_reg   <= '0;
            bout_sum_reg  <= '0;
        end else if (wr_en) begin
            ring_pos_reg <= ring_pos_next;
            if (wrap) begin
                ring_full_reg <= 1'b1;
            end
            det_sum_reg  <= det_sum_reg + SUM_W'(det_inc) - SUM_W'(det_dec);
            bout_sum_reg <= bout_sum_reg + SUM_W'(bout_inc) - SUM_W'(bout_dec);
        end
    end

    assign det_sum  = det_sum_reg;
    assign bout_sum = bout_sum_reg;
    assign filled   = ring_full_reg ? SUM_W'(DEPTH) : SUM_W'(ring_pos_reg);

    a_bout_within_det: assert property (@(posedge aclk) disable iff (!aresetn)
        bout_sum_reg <= det_sum_reg)
        else $error("bout count exceeds detection count");

    a_det_within_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !ring_full_reg |-> (det_sum_reg <= SUM_W'(ring_pos_reg)))
        else $error("detection count exceeds filled entries");

    a_wrap_sets_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && wrap) |=> (ring_full_reg && ring_pos_reg == '0))
        else $error("ring wrap did not mark history full");

endmodule

>>> rtl/core/snore_event_detector_core.sv
// ----------------------------------------------------------------------------
// snore_event_detector_core
// Windowed peak-to-peak snore detector with bout tracking and grading.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle while s_tready is high, samples and window
// closes alike. A sample (tuser 0) only updates the running window extremes
// and gives no result. A window close (tuser 1) raises m_tvalid once it has
// passed window snapshot, then spread, then snore/bout decision with ring
// update, then grading straight into the output register. The class ring
// sits in a single-port-write RAM whose next entry is read ahead into a
// register, so closes may follow each other every cycle. A two-entry output
// stage absorbs back-pressure; s_tready drops only when both entries hold
// results. The ring needs no clearing pass after reset.
module snore_event_detector_core #(
    parameter int unsigned HISTORY_DEPTH = 50
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sed_pkg::S_TDATA_W-1:0]     s_tdata,   // sample[31:0], now_ms[63:32]
    input  logic [0:0]                        s_tuser,   // command[0]

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // peak_to_peak[31:0], detected[32], new_bout[33], snore_total[49:34],
    // bout_total[65:50], recent_detections[71:66], recent_bouts[77:72],
    // recent_grade[79:78], overall_score[81:80], score_valid[82], zero pad
    output logic [sed_pkg::M_TDATA_W-1:0]     m_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sed_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sed_pkg::DATA_W-1:0]        cfg_data
);

    localparam int unsigned SUM_W = $clog2(HISTORY_DEPTH+1);
    localparam int unsigned EXT_W = SUM_W + sed_pkg::SMALL_W;
    localparam int unsigned DW    = sed_pkg::DATA_W;
    localparam int unsigned CW    = sed_pkg::COUNT_W;
    localparam int unsigned SW    = sed_pkg::SMALL_W;

    // configuration
    logic [DW-1:0] snore_threshold_reg;
    logic [DW-1:0] bout_gap_ms_reg;
    logic [DW-1:0] score_delay_ms_reg;
    logic [SW-1:0] min_windows_reg;
    logic [SW-1:0] poor_det_limit_reg;
    logic [SW-1:0] fair_det_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snore_threshold_reg <= sed_pkg::RST_SNORE_THRESHOLD;
            bout_gap_ms_reg     <= sed_pkg::RST_BOUT_GAP_MS;
            score_delay_ms_reg  <= sed_pkg::RST_SCORE_DELAY_MS;
            min_windows_reg     <= sed_pkg::RST_MIN_WINDOWS;
            poor_det_limit_reg  <= sed_pkg::RST_POOR_DET_LIMIT;
            fair_det_limit_reg  <= sed_pkg::RST_FAIR_DET_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sed_pkg::CFG_SNORE_THRESHOLD: snore_threshold_reg <= cfg_data;
                sed_pkg::CFG_BOUT_GAP_MS:     bout_gap_ms_reg     <= cfg_data;
                sed_pkg::CFG_SCORE_DELAY_MS:  score_delay_ms_reg  <= cfg_data;
                sed_pkg::CFG_MIN_WINDOWS:     min_windows_reg     <= cfg_data[SW-1:0];
                sed_pkg::CFG_POOR_DET_LIMIT:  poor_det_limit_reg  <= cfg_data[SW-1:0];
                sed_pkg::CFG_FAIR_DET_LIMIT:  fair_det_limit_reg  <= cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    logic out_valid_reg;
    logic skid_valid_reg;
    logic adv;
    logic s_accept;
    logic in_cmd;
    logic [DW-1:0] in_sample;
    logic [DW-1:0] in_now;
    logic [DW-1:0] in_biased;

    assign adv       = !skid_valid_reg;
    assign s_tready  = adv;
    assign s_accept  = s_tvalid && s_tready;
    assign in_cmd    = s_tuser[0];
    assign in_sample = s_tdata[DW-1:0];
    assign in_now    = s_tdata[2*DW-1:DW];
    assign in_biased = in_sample ^ sed_pkg::SIGN_BIAS;

    // running window
    logic [DW-1:0] win_max_reg;
    logic [DW-1:0] win_min_reg;
    logic          win_has_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_max_reg <= sed_pkg::WIN_MAX_RST;
            win_min_reg <= sed_pkg::WIN_MIN_RST;
            win_has_reg <= 1'b0;
        end else if (s_accept) begin
            if (in_cmd == sed_pkg::CMD_CLOSE) begin
                win_max_reg <= sed_pkg::WIN_MAX_RST;
                win_min_reg <= sed_pkg::WIN_MIN_RST;
                win_has_reg <= 1'b0;
            end else if (in_sample != '0) begin
                win_has_reg <= 1'b1;
                if (in_biased > win_max_reg) begin
                    win_max_reg <= in_biased;
                end
                if (in_biased < win_min_reg) begin
                    win_min_reg <= in_biased;
                end
            end
        end
    end

    // stage valids
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_accept && (in_cmd == sed_pkg::CMD_CLOSE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: closed window snapshot
    logic [DW-1:0] p1_max_reg;
    logic [DW-1:0] p1_min_reg;
    logic          p1_has_reg;
    logic [DW-1:0] p1_now_reg;

    always_ff @(posedge aclk) begin
        if (s_accept && in_cmd == sed_pkg::CMD_CLOSE) begin
            p1_max_reg <= win_max_reg;
            p1_min_reg <= win_min_reg;
            p1_has_reg <= win_has_reg;
            p1_now_reg <= in_now;
        end
    end

    // stage 2: spread and score validity
    logic [DW-1:0] p2_p2p_reg;
    logic [DW-1:0] p2_now_reg;
    logic          p2_score_valid_reg;
    logic [DW-1:0] p2p_next;

    always_comb begin
        p2p_next = '0;
        if (p1_has_reg && p1_max_reg > p1_min_reg) begin
            p2p_next = p1_max_reg - p1_min_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_p2p_reg         <= p2p_next;
            p2_now_reg         <= p1_now_reg;
            p2_score_valid_reg <= (p1_now_reg >= score_delay_ms_reg);
        end
    end

    // stage 2 work: snore, bout, totals, ring update
    logic [CW-1:0]   snore_cnt_reg;
    logic [CW-1:0]   bout_cnt_reg;
    logic [DW-1:0]   last_snore_reg;
    logic            ever_snored_reg;
    logic            det;
    logic            new_bout;
    logic [DW-1:0]   gap;
    logic            hist_wr;
    sed_pkg::class_t cls;

    assign det      = (p2_p2p_reg > snore_threshold_reg);
    assign gap      = p2_now_reg - last_snore_reg;
    assign new_bout = det && (!ever_snored_reg || gap > bout_gap_ms_reg);
    assign hist_wr  = adv && v2_reg;

    always_comb begin
        if (new_bout) begin
            cls = sed_pkg::CLASS_BOUT;
        end else if (det) begin
            cls = sed_pkg::CLASS_SNORE;
        end else begin
            cls = sed_pkg::CLASS_QUIET;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snore_cnt_reg   <= '0;
            bout_cnt_reg    <= '0;
            last_snore_reg  <= '0;
            ever_snored_reg <= 1'b0;
        end else if (hist_wr && det) begin
            if (snore_cnt_reg != sed_pkg::COUNT_MAX) begin
                snore_cnt_reg <= snore_cnt_reg + CW'(1);
            end
            if (new_bout && bout_cnt_reg != sed_pkg::COUNT_MAX) begin
                bout_cnt_reg <= bout_cnt_reg + CW'(1);
            end
            last_snore_reg  <= p2_now_reg;
            ever_snored_reg <= 1'b1;
        end
    end

    logic [SUM_W-1:0] det_sum;
    logic [SUM_W-1:0] bout_sum;
    logic [SUM_W-1:0] filled;

    sed_history #(
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (hist_wr),
        .wr_class (cls),
        .det_sum  (det_sum),
        .bout_sum (bout_sum),
        .filled   (filled)
    );

    // stage 3: per-window fields; shared state already reflects this window
    logic [DW-1:0] p3_p2p_reg;
    logic          p3_det_reg;
    logic          p3_bout_reg;
    logic          p3_score_valid_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_p2p_reg         <= p2_p2p_reg;
            p3_det_reg         <= det;
            p3_bout_reg        <= new_bout;
            p3_score_valid_reg <= p2_score_valid_reg;
        end
    end

    logic [EXT_W-1:0]  det_ext;
    logic [EXT_W-1:0]  bout_ext;
    logic [EXT_W-1:0]  filled_ext;
    sed_pkg::grade_t   grade;
    sed_pkg::score_t   score;
    logic [sed_pkg::M_TDATA_W-1:0] result;

    assign det_ext    = EXT_W'(det_sum);
    assign bout_ext   = EXT_W'(bout_sum);
    assign filled_ext = EXT_W'(filled);

    always_comb begin
        if (filled_ext < EXT_W'(min_windows_reg)) begin
            grade = sed_pkg::GRADE_CALIB;
        end else if (det_ext >= EXT_W'(poor_det_limit_reg)
                     || bout_ext >= EXT_W'(sed_pkg::RECENT_BOUT_POOR)) begin
            grade = sed_pkg::GRADE_POOR;
        end else if (det_ext >= EXT_W'(fair_det_limit_reg)
                     || bout_ext >= EXT_W'(sed_pkg::RECENT_BOUT_FAIR)) begin
            grade = sed_pkg::GRADE_FAIR;
        end else begin
            grade = sed_pkg::GRADE_GOOD;
        end
    end

    assign score = p3_score_valid_reg ? sed_pkg::overall_of(snore_cnt_reg, bout_cnt_reg)
                                      : sed_pkg::SCORE_GOOD;

    always_comb begin
        result        = '0;
        result[31:0]  = p3_p2p_reg;
        result[32]    = p3_det_reg;
        result[33]    = p3_bout_reg;
        result[49:34] = snore_cnt_reg;
        result[65:50] = bout_cnt_reg;
        result[71:66] = det_ext[SW-1:0];
        result[77:72] = bout_ext[SW-1:0];
        result[79:78] = grade;
        result[81:80] = score;
        result[82]    = p3_score_valid_reg;
    end

    // output register with skid entry
    logic [sed_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [sed_pkg::M_TDATA_W-1:0] skid_data_reg;
    logic                          out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (adv) begin
            if (v3_reg) begin
                if (out_free) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end else if (m_tready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (v3_reg) begin
                if (out_free) begin
                    out_data_reg <= result;
                end else begin
                    skid_data_reg <= result;
                end
            end
        end else if (m_tready) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_bout_needs_snore: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && p3_bout_reg) |-> p3_det_reg)
        else $error("bout flagged on a window without a snore");

    a_bouts_within_snores: assert property (@(posedge aclk) disable iff (!aresetn)
        bout_cnt_reg <= snore_cnt_reg)
        else $error("bout total exceeds snore total");

    a_stall_freezes_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |-> !hist_wr)
        else $error("history written while output stage is full");

endmodule
